FILE: hw/rtl/pabm_pkg.sv
// Shared types, constants and codes of the per-ID allocation burst monitor.
`default_nettype none

package pabm_pkg;

	localparam int TABLE_ENTRIES = 128;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	localparam int ID_W  = 22;
	localparam int LEN_W = 48;
	localparam int TS_W  = 63;
	localparam int WIN_W = 40;
	localparam int ALU_W = 64;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(64'd1000000000);
	localparam logic [LEN_W-1:0] TOTAL_MAX = {LEN_W{1'b1}};

	// item kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_ADD    = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	// result status codes
	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_ALERT   = 3'd1;
	localparam logic [2:0] ST_IGNORED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_DONE    = 3'd4;

	// config register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ID_W-1:0]  proc_id;
		logic [LEN_W-1:0] length;
		logic [TS_W-1:0]  timestamp_ns;
	} pabm_in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [ID_W-1:0]  alert_id;
		logic [LEN_W-1:0] alert_total;
		logic [LEN_W-1:0] alert_threshold;
	} pabm_out_t;

	// table write request
	typedef struct packed {
		logic [IDX_W-1:0] addr;
		logic             id_we;
		logic [ID_W-1:0]  id;
		logic             data_we;
		logic [TS_W-1:0]  last_seen;
		logic [LEN_W-1:0] total;
		logic             set_managed;
		logic             clr_managed;
		logic             set_stats;
		logic             clr_stats;
	} tbl_wr_t;

	// outcome of one table scan
	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] found_idx;
		logic             free;
		logic [IDX_W-1:0] free_idx;
	} scan_res_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] res;
		logic             cout;
	} alu_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pabm_table.sv
// Entry table: managed/stats flags in flops, ID, timestamp and total in memories.
`default_nettype none

module pabm_table
	import pabm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] scan_addr,
	output logic      [ID_W-1:0]  scan_id,
	output logic                  scan_managed,
	input  wire logic [IDX_W-1:0] upd_addr,
	output logic      [TS_W-1:0]  upd_last_seen,
	output logic      [LEN_W-1:0] upd_total,
	output logic                  upd_stats,
	input  wire tbl_wr_t          wr
);

	logic [TABLE_ENTRIES-1:0] managed_q;
	logic [TABLE_ENTRIES-1:0] stats_q;

	logic [ID_W-1:0]  id_mem  [TABLE_ENTRIES];
	logic [TS_W-1:0]  ls_mem  [TABLE_ENTRIES];
	logic [LEN_W-1:0] tot_mem [TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			managed_q <= '0;
			stats_q   <= '0;
		end else begin
			if (wr.set_managed) managed_q[wr.addr] <= 1'b1;
			if (wr.clr_managed) managed_q[wr.addr] <= 1'b0;
			if (wr.set_stats)   stats_q[wr.addr]   <= 1'b1;
			if (wr.clr_stats)   stats_q[wr.addr]   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.id_we) id_mem[wr.addr] <= wr.id;
		scan_id      <= id_mem[scan_addr];
		scan_managed <= managed_q[scan_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.data_we) begin
			ls_mem[wr.addr]  <= wr.last_seen;
			tot_mem[wr.addr] <= wr.total;
		end
		upd_last_seen <= ls_mem[upd_addr];
		upd_total     <= tot_mem[upd_addr];
		upd_stats     <= stats_q[upd_addr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/pabm_alu.sv
// Shared 64-bit add/subtract unit with carry out.
`default_nettype none

module pabm_alu
	import pabm_pkg::*;
(
	input  wire alu_req_t req,
	output alu_rsp_t      rsp
);

	logic [ALU_W-1:0] b_eff;
	logic [ALU_W:0]   sum;

	// subtract as a + ~b + 1; carry out low means a borrow (a < b)
	assign b_eff = req.sub ? ~req.b : req.b;
	assign sum = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.sub};
	assign rsp.res  = sum[ALU_W-1:0];
	assign rsp.cout = sum[ALU_W];

endmodule

`default_nettype wire

FILE: hw/rtl/pabm_scan.sv
// Linear table scan: first managed entry with a matching ID and first free entry.
`default_nettype none

module pabm_scan
	import pabm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [ID_W-1:0]  key,
	output logic      [IDX_W-1:0] scan_addr,
	input  wire logic [ID_W-1:0]  scan_id,
	input  wire logic             scan_managed,
	output scan_res_t             res
);

	logic             on_q;
	logic [CNT_W-1:0] cnt_q;
	logic             chk_q;
	logic [IDX_W-1:0] chk_idx_q;
	logic             done_q;
	logic             found_q;
	logic [IDX_W-1:0] found_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             hit;

	assign scan_addr = cnt_q[IDX_W-1:0];
	assign hit = scan_managed && (scan_id == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q        <= 1'b0;
			cnt_q       <= '0;
			chk_q       <= 1'b0;
			chk_idx_q   <= '0;
			done_q      <= 1'b0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				on_q    <= 1'b1;
				cnt_q   <= '0;
				chk_q   <= 1'b0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (on_q) begin
				// read issue
				if (cnt_q < CNT_W'(TABLE_ENTRIES)) begin
					chk_q     <= 1'b1;
					chk_idx_q <= cnt_q[IDX_W-1:0];
					cnt_q     <= cnt_q + CNT_W'(1);
				end else begin
					chk_q <= 1'b0;
				end
				// check of last cycle's read
				if (chk_q) begin
					if (hit) begin
						found_q     <= 1'b1;
						found_idx_q <= chk_idx_q;
					end
					if (!scan_managed && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= chk_idx_q;
					end
					if (hit || chk_idx_q == IDX_W'(TABLE_ENTRIES - 1)) begin
						on_q   <= 1'b0;
						chk_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	assign res.done      = done_q;
	assign res.found     = found_q;
	assign res.found_idx = found_idx_q;
	assign res.free      = free_q;
	assign res.free_idx  = free_idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/per_id_allocation_burst_monitor_unit.sv
// Top level of the per-ID allocation burst monitor: sequencer, config and result.
`default_nettype none

// Usage
//   Input: drive item and raise start; the transfer happens at a rising edge
//   with start high and busy low. busy stays high until the item is finished.
//   Output: exactly one result per item, shown on result for one cycle with
//   result_valid high. The receiver cannot stall; it must take it then.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//   Index 0 is threshold_bytes (48 bits), index 1 is window_ns (low 40 bits
//   of cfg_data); other indexes are dropped. Write only while idle.
// Sequence
//   The table is scanned one entry per cycle through the ID memory's single
//   read port. A scan that runs to the end (add of a new ID, remove or event
//   for an unmanaged ID) gives the result after the last entry is checked.
//   A scan stops on a match: add/remove then answer when the scan ends, an
//   allocation event goes on through a table read and four more steps through
//   the one shared add/subtract unit: gap, window compare, sum, threshold compare.
//   Unused kind 3 skips the scan: result_valid rises at the accept edge.
//   busy falls at the edge that raises result_valid; the next transfer can come while result_valid is high.
// Reset: asynchronous; all entries unmanaged, threshold 0, window 1e9 ns.

module per_id_allocation_burst_monitor_unit
	import pabm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire pabm_in_t              item,
	output logic                       result_valid,
	output pabm_out_t                  result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_GAP  = 3'd3;
	localparam logic [2:0] S_WIN  = 3'd4;
	localparam logic [2:0] S_ADD  = 3'd5;
	localparam logic [2:0] S_THR  = 3'd6;

	logic [2:0]       state_q;
	logic             res_valid_q;
	pabm_out_t        res_q;
	pabm_out_t        res_d;
	logic             emit;
	logic             accept;
	logic             alert;

	logic [LEN_W-1:0] thr_q;
	logic [WIN_W-1:0] win_q;

	pabm_in_t         item_q;
	logic [IDX_W-1:0] ent_idx_q;
	logic [TS_W-1:0]  gap_q;
	logic             restart_q;
	logic [LEN_W-1:0] sum_q;

	logic [IDX_W-1:0] scan_addr;
	logic [ID_W-1:0]  scan_id;
	logic             scan_managed;
	scan_res_t        scan_res;
	logic [TS_W-1:0]  upd_last_seen;
	logic [LEN_W-1:0] upd_total;
	logic             upd_stats;
	tbl_wr_t          wr;
	alu_req_t         alu_req;
	alu_rsp_t         alu_rsp;

	assign busy         = (state_q != S_IDLE);
	assign accept       = start && !busy;
	assign cfg_ready    = 1'b1;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	pabm_table u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.scan_addr     (scan_addr),
		.scan_id       (scan_id),
		.scan_managed  (scan_managed),
		.upd_addr      (ent_idx_q),
		.upd_last_seen (upd_last_seen),
		.upd_total     (upd_total),
		.upd_stats     (upd_stats),
		.wr            (wr)
	);

	pabm_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (accept && (item.kind != KIND_RSVD)),
		.key          (item_q.proc_id),
		.scan_addr    (scan_addr),
		.scan_id      (scan_id),
		.scan_managed (scan_managed),
		.res          (scan_res)
	);

	pabm_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// threshold compare: thr - sum borrows when the sum is above the threshold
	assign alert = !alu_rsp.cout;

	// operand steering, table writes and the result word
	always_comb begin
		emit                  = 1'b0;
		res_d.status          = ST_IGNORED;
		res_d.alert_id        = item_q.proc_id;
		res_d.alert_total     = '0;
		res_d.alert_threshold = '0;
		wr                    = '0;
		alu_req               = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && item.kind == KIND_RSVD) begin
					emit           = 1'b1;
					res_d.alert_id = item.proc_id;
				end
			end
			S_SCAN: begin
				if (scan_res.done) begin
					case (item_q.kind)
						KIND_ALLOC: begin
							emit = !scan_res.found;
						end
						KIND_ADD: begin
							emit = 1'b1;
							if (scan_res.found) begin
								wr.addr      = scan_res.found_idx;
								wr.data_we   = 1'b1;
								wr.clr_stats = 1'b1;
								res_d.status = ST_DONE;
							end else if (scan_res.free) begin
								wr.addr        = scan_res.free_idx;
								wr.id_we       = 1'b1;
								wr.id          = item_q.proc_id;
								wr.set_managed = 1'b1;
								wr.data_we     = 1'b1;
								wr.clr_stats   = 1'b1;
								res_d.status   = ST_DONE;
							end else begin
								res_d.status = ST_FULL;
							end
						end
						KIND_REMOVE: begin
							emit         = 1'b1;
							res_d.status = ST_DONE;
							if (scan_res.found) begin
								wr.addr        = scan_res.found_idx;
								wr.clr_managed = 1'b1;
								wr.clr_stats   = 1'b1;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_GAP: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(item_q.timestamp_ns);
				alu_req.b   = ALU_W'(upd_last_seen);
			end
			S_WIN: begin
				alu_req.sub = 1'b1;
				alu_req.a   = ALU_W'(win_q);
				alu_req.b   = ALU_W'(gap_q);
			end
			S_ADD: begin
				alu_req.sub = 1'b0;
				alu_req.a   = ALU_W'(upd_total);
				alu_req.b   = ALU_W'(item_q.length);
			end
			S_THR: begin
				alu_req.sub  = 1'b1;
				alu_req.a    = ALU_W'(thr_q);
				alu_req.b    = ALU_W'(sum_q);
				emit         = 1'b1;
				wr.addr      = ent_idx_q;
				wr.data_we   = 1'b1;
				wr.last_seen = item_q.timestamp_ns;
				wr.total     = alert ? '0 : sum_q;
				wr.set_stats = 1'b1;
				if (alert) begin
					res_d.status          = ST_ALERT;
					res_d.alert_total     = sum_q;
					res_d.alert_threshold = thr_q;
				end else begin
					res_d.status = ST_COUNTED;
				end
			end
			default: begin
			end
		endcase
	end

	// control: sequencer state, result strobe, config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			thr_q       <= '0;
			win_q       <= WINDOW_RESET;
		end else begin
			res_valid_q <= emit;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_THRESHOLD: thr_q <= cfg_data;
					CFG_WINDOW:    win_q <= cfg_data[WIN_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept && item.kind != KIND_RSVD) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_res.done) begin
						if (item_q.kind == KIND_ALLOC && scan_res.found) state_q <= S_READ;
						else state_q <= S_IDLE;
					end
				end
				S_READ:  state_q <= S_GAP;
				S_GAP:   state_q <= S_WIN;
				S_WIN:   state_q <= S_ADD;
				S_ADD:   state_q <= S_THR;
				S_THR:   state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (emit) res_q <= res_d;
		case (state_q)
			S_SCAN: begin
				if (scan_res.done) ent_idx_q <= scan_res.found_idx;
			end
			S_GAP: begin
				// gap wraps modulo 2^63, so time going backwards reads as huge
				gap_q <= alu_rsp.res[TS_W-1:0];
			end
			S_WIN: begin
				// window - gap borrows when the gap exceeds the window
				restart_q <= !upd_stats || !alu_rsp.cout;
			end
			S_ADD: begin
				if (restart_q) sum_q <= item_q.length;
				else if (alu_rsp.res[LEN_W]) sum_q <= TOTAL_MAX;
				else sum_q <= alu_rsp.res[LEN_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// a result only ever closes out an item in flight or a reserved-kind transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($past(busy) || $past(start)))
		else $error("result without a pending item");

	// an accepted item that needs a scan makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.kind != KIND_RSVD) |=> busy)
		else $error("item accepted without going busy");

	// an alert carries a total strictly above its threshold
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == ST_ALERT)
			|-> (result.alert_total > result.alert_threshold))
		else $error("alert total not above threshold");

	// only alerts report totals
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_ALERT)
			|-> (result.alert_total == '0 && result.alert_threshold == '0))
		else $error("non-alert result carries a total");

	// the scan reports completion only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> (state_q == S_SCAN))
		else $error("scan finished outside the scan step");

endmodule

`default_nettype wire
